// File: sv/lzss_pkg.sv
// Shared types and constants of the LZSS ring decoder.
package lzss_pkg;

  localparam int BYTE_W = 8;
  localparam int POS_W  = 12;
  localparam int LEN_W  = 5;
  localparam int MAX_CODE = 15;

  localparam logic [BYTE_W-1:0] SPACE_BYTE = 8'h20;
  localparam logic [2:0]        FLAGS_PER_BYTE_M1 = 3'd7;

  typedef enum logic [1:0] {
    PH_FLAG    = 2'd0,
    PH_LIT     = 2'd1,
    PH_PAIR_LO = 2'd2,
    PH_PAIR_HI = 2'd3
  } phase_e;

  typedef enum logic [2:0] {
    S_SWEEP = 3'd0,
    S_IDLE  = 3'd1,
    S_LIT   = 3'd2,
    S_MOD   = 3'd3,
    S_RD    = 3'd4,
    S_WR    = 3'd5
  } state_e;

endpackage

// File: sv/lzss_if.sv
// Stream interfaces for compressed input items and decompressed output items.
interface lzss_in_if;
  import lzss_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] in_byte;
  logic              in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface lzss_out_if;
  import lzss_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              out_last;

  modport source (output valid, output out_byte, output out_last, input ready);
  modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

// File: sv/lzss_ring.sv
// History ring memory: one write port, one read port with registered data.
module lzss_ring #(
  parameter int RING_SIZE = 4096,
  parameter int AW        = 12
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [AW-1:0]              waddr_i,
  input  logic [lzss_pkg::BYTE_W-1:0] wdata_i,
  input  logic                       re_i,
  input  logic [AW-1:0]              raddr_i,
  output logic [lzss_pkg::BYTE_W-1:0] rdata_o
);
  import lzss_pkg::*;

  logic [BYTE_W-1:0] mem [RING_SIZE];
  logic [BYTE_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/lzss_mod.sv
// Iterative compare-subtract unit that reduces a match position modulo the ring size.
module lzss_mod #(
  parameter int RING_SIZE = 4096,
  parameter int AW        = 12
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [lzss_pkg::POS_W-1:0] pos_i,
  output logic                      done_o,
  output logic [AW-1:0]             result_o
);
  import lzss_pkg::*;

  localparam int MAXSH = POS_W - AW;
  localparam int SH_W  = $clog2(MAXSH + 2);
  localparam logic [POS_W:0] RING_EXT = (POS_W + 1)'(RING_SIZE);

  logic             busy_q, busy_d;
  logic [SH_W-1:0]  sh_q, sh_d;
  logic [POS_W-1:0] rem_q, rem_d;
  logic [POS_W:0]   dv;
  logic [POS_W-1:0] step_rem;

  assign dv = RING_EXT << sh_q;

  always_comb begin
    if ({1'b0, rem_q} >= dv) begin
      step_rem = rem_q - dv[POS_W-1:0];
    end else begin
      step_rem = rem_q;
    end
  end

  always_comb begin
    busy_d = busy_q;
    sh_d   = sh_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      sh_d   = SH_W'(MAXSH);
      rem_d  = pos_i;
    end else if (busy_q) begin
      rem_d = step_rem;
      if (sh_q == '0) begin
        busy_d = 1'b0;
      end else begin
        sh_d = sh_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q  <= sh_d;
    rem_q <= rem_d;
  end

  assign done_o   = busy_q && (sh_q == '0);
  assign result_o = step_rem[AW-1:0];

endmodule

// File: sv/lzss_ring_decoder.sv
// Top level of the LZSS decoder: parse sequencer, output register and ring control.
//
// Compressed bytes enter on in_i, one item per valid/ready handshake; decompressed
// bytes leave on out_o, one item per handshake, with out_last set on the final
// byte caused by an input item marked in_last.
// After reset the block sweeps the whole ring to spaces, one entry per cycle,
// with in_i.ready low. A flag byte or the first byte of a pair is taken in the
// idle state. A literal is taken, then written to the ring and the output
// register once that is free. The second byte of a pair starts the position
// reduction unit; then each copied byte (3 to 18 bytes) goes through a read
// state and a write state, set by the single ring read port and its registered
// read data. After an item marked in_last the first RING_SIZE-MAX_LEN ring
// entries (RING_SIZE-18 at the default) are swept back to spaces before the
// next stream is taken.
// Results go through a one-entry output register; when out_o.ready is low the
// sequencer holds at the next byte and does not write the ring until it drains.
// in_i.ready is high only while the sequencer waits for a new item.
module lzss_ring_decoder #(
  parameter int RING_SIZE = 4096,
  parameter int MIN_MATCH = 3
) (
  input  logic clk_i,
  input  logic rst_ni,
  lzss_in_if.sink    in_i,
  lzss_out_if.source out_o
);
  import lzss_pkg::*;

  localparam int AW         = $clog2(RING_SIZE);
  localparam int MAX_LEN    = MAX_CODE + MIN_MATCH;
  localparam int REFILL_LEN = (RING_SIZE > MAX_LEN) ? (RING_SIZE - MAX_LEN) : 0;
  localparam logic [AW-1:0] WP_INIT    = AW'(REFILL_LEN % RING_SIZE);
  localparam logic [AW-1:0] FULL_END   = AW'(RING_SIZE - 1);
  localparam logic [AW-1:0] REFILL_END = AW'((REFILL_LEN > 0) ? (REFILL_LEN - 1) : 0);
  localparam logic          HAS_REFILL = (REFILL_LEN > 0);

  state_e            state_q, state_d;
  phase_e            phase_q, phase_d;
  logic [BYTE_W-1:0] flags_q, flags_d;
  logic [2:0]        frem_q, frem_d;
  logic [BYTE_W-1:0] pair_lo_q, pair_lo_d;
  logic [BYTE_W-1:0] byte_q, byte_d;
  logic              last_q, last_d;
  logic [AW-1:0]     wp_q, wp_d;
  logic [AW-1:0]     rd_q, rd_d;
  logic [LEN_W-1:0]  cnt_q, cnt_d;
  logic [AW-1:0]     sw_q, sw_d;
  logic              full_q, full_d;
  logic              out_valid_q, out_valid_d;
  logic [BYTE_W-1:0] out_byte_q, out_byte_d;
  logic              out_last_q, out_last_d;

  logic              in_acc;
  logic              slot_free;
  logic              sweep_end;
  logic              finish;
  logic              ring_we, ring_re;
  logic [AW-1:0]     ring_waddr;
  logic [BYTE_W-1:0] ring_wdata;
  logic [BYTE_W-1:0] ring_rdata;
  logic              mod_start, mod_done;
  logic [AW-1:0]     mod_res;
  logic [POS_W-1:0]  pair_pos;
  logic [BYTE_W-1:0] next_flags;

  function automatic logic [AW-1:0] ring_inc(input logic [AW-1:0] x);
    logic [AW-1:0] r;
    if (x == FULL_END) begin
      r = '0;
    end else begin
      r = x + 1'b1;
    end
    return r;
  endfunction

  assign in_i.ready   = (state_q == S_IDLE);
  assign in_acc       = in_i.valid && in_i.ready;
  assign slot_free    = !out_valid_q || out_o.ready;
  assign sweep_end    = full_q ? (sw_q == FULL_END) : (sw_q == REFILL_END);
  assign pair_pos     = {in_i.in_byte[7:4], pair_lo_q};
  assign next_flags   = flags_q >> 1;

  assign out_o.valid    = out_valid_q;
  assign out_o.out_byte = out_byte_q;
  assign out_o.out_last = out_last_q;

  lzss_ring #(
    .RING_SIZE (RING_SIZE),
    .AW        (AW)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ring_we),
    .waddr_i (ring_waddr),
    .wdata_i (ring_wdata),
    .re_i    (ring_re),
    .raddr_i (rd_q),
    .rdata_o (ring_rdata)
  );

  lzss_mod #(
    .RING_SIZE (RING_SIZE),
    .AW        (AW)
  ) u_mod (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (mod_start),
    .pos_i    (pair_pos),
    .done_o   (mod_done),
    .result_o (mod_res)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_SWEEP: begin
        if (sweep_end) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          unique case (phase_q)
            PH_LIT:     state_d = S_LIT;
            PH_PAIR_HI: state_d = S_MOD;
            default: begin
              if (in_i.in_last && HAS_REFILL) begin
                state_d = S_SWEEP;
              end
            end
          endcase
        end
      end
      S_LIT: begin
        if (slot_free) begin
          state_d = (last_q && HAS_REFILL) ? S_SWEEP : S_IDLE;
        end
      end
      S_MOD: begin
        if (mod_done) begin
          state_d = S_RD;
        end
      end
      S_RD: begin
        state_d = S_WR;
      end
      S_WR: begin
        if (slot_free) begin
          if (cnt_q == LEN_W'(1)) begin
            state_d = (last_q && HAS_REFILL) ? S_SWEEP : S_IDLE;
          end else begin
            state_d = S_RD;
          end
        end
      end
      default: state_d = S_SWEEP;
    endcase
  end

  always_comb begin
    phase_d     = phase_q;
    flags_d     = flags_q;
    frem_d      = frem_q;
    pair_lo_d   = pair_lo_q;
    byte_d      = byte_q;
    last_d      = last_q;
    wp_d        = wp_q;
    rd_d        = rd_q;
    cnt_d       = cnt_q;
    sw_d        = sw_q;
    full_d      = full_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_byte_d  = out_byte_q;
    out_last_d  = out_last_q;
    ring_we     = 1'b0;
    ring_waddr  = wp_q;
    ring_wdata  = ring_rdata;
    ring_re     = 1'b0;
    mod_start   = 1'b0;
    finish      = 1'b0;

    unique case (state_q)
      S_SWEEP: begin
        ring_we    = 1'b1;
        ring_waddr = sw_q;
        ring_wdata = SPACE_BYTE;
        sw_d       = ring_inc(sw_q);
        if (sweep_end) begin
          sw_d   = '0;
          full_d = 1'b0;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          byte_d = in_i.in_byte;
          last_d = in_i.in_last;
          unique case (phase_q)
            PH_FLAG: begin
              flags_d = in_i.in_byte;
              frem_d  = FLAGS_PER_BYTE_M1;
              phase_d = in_i.in_byte[0] ? PH_LIT : PH_PAIR_LO;
            end
            PH_PAIR_LO: begin
              pair_lo_d = in_i.in_byte;
              phase_d   = PH_PAIR_HI;
            end
            PH_PAIR_HI: begin
              mod_start = 1'b1;
              cnt_d     = LEN_W'(in_i.in_byte[3:0]) + LEN_W'(MIN_MATCH);
            end
            default: ;
          endcase
          if (in_i.in_last && (phase_q == PH_FLAG || phase_q == PH_PAIR_LO)) begin
            phase_d = PH_FLAG;
            frem_d  = '0;
            wp_d    = WP_INIT;
          end
        end
      end
      S_LIT: begin
        if (slot_free) begin
          ring_we     = 1'b1;
          ring_wdata  = byte_q;
          out_valid_d = 1'b1;
          out_byte_d  = byte_q;
          out_last_d  = last_q;
          wp_d        = ring_inc(wp_q);
          finish      = 1'b1;
        end
      end
      S_MOD: begin
        if (mod_done) begin
          rd_d = mod_res;
        end
      end
      S_RD: begin
        ring_re = 1'b1;
      end
      S_WR: begin
        if (slot_free) begin
          ring_we     = 1'b1;
          out_valid_d = 1'b1;
          out_byte_d  = ring_rdata;
          out_last_d  = last_q && (cnt_q == LEN_W'(1));
          wp_d        = ring_inc(wp_q);
          rd_d        = ring_inc(rd_q);
          cnt_d       = cnt_q - 1'b1;
          finish      = (cnt_q == LEN_W'(1));
        end
      end
      default: ;
    endcase

    if (finish) begin
      if (last_q) begin
        phase_d = PH_FLAG;
        frem_d  = '0;
        wp_d    = WP_INIT;
      end else if (frem_q != '0) begin
        flags_d = next_flags;
        frem_d  = frem_q - 1'b1;
        phase_d = next_flags[0] ? PH_LIT : PH_PAIR_LO;
      end else begin
        phase_d = PH_FLAG;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_SWEEP;
      phase_q     <= PH_FLAG;
      flags_q     <= '0;
      frem_q      <= '0;
      wp_q        <= WP_INIT;
      sw_q        <= '0;
      full_q      <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      flags_q     <= flags_d;
      frem_q      <= frem_d;
      wp_q        <= wp_d;
      sw_q        <= sw_d;
      full_q      <= full_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pair_lo_q  <= pair_lo_d;
    byte_q     <= byte_d;
    last_q     <= last_d;
    rd_q       <= rd_d;
    cnt_q      <= cnt_d;
    out_byte_q <= out_byte_d;
    out_last_q <= out_last_d;
  end

  a_mod_done_in_mod: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mod_done |-> (state_q == S_MOD))
    else $error("position reduction finished outside its state");

  a_ring_one_port: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ring_we && ring_re))
    else $error("ring read and write in the same cycle");

  a_last_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_i.in_last && HAS_REFILL) |=> !in_i.ready)
    else $error("input taken right after end of stream");

  a_out_hold_when_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_o.ready && (state_q == S_WR)) |=> (state_q == S_WR))
    else $error("copy advanced while output stalled");

endmodule

// File: tb/sv/tb_lzss_ring_decoder.sv
// Self-checking testbench for the LZSS ring decoder: directed table, random streams, byte predictor.
module tb_lzss_ring_decoder;
  import lzss_pkg::*;

  localparam int RING_N       = 4096;
  localparam int RING_AW      = $clog2(RING_N);
  localparam int MIN_RUN      = 3;
  localparam int MAX_RUN      = MAX_CODE + MIN_RUN;
  localparam int REFILL_N     = (RING_N > MAX_RUN) ? RING_N - MAX_RUN : 0;
  localparam int RANDOM_ITEMS = 215;
  localparam int IDLE_LIMIT   = 20000;
  localparam int TAIL_CYCLES  = 80;
  localparam int DIR_ROWS     = 23;
  localparam int PRINT_CAP    = 100;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
  } out_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
    logic              typed;
    logic [4:0]        count;
    logic [BYTE_W-1:0] value;
  } stim_row_t;

  // data, last, typed, count, value
  localparam stim_row_t DIRECTED [DIR_ROWS] = '{
    '{8'hFC, 1'b0, 1'b1, 5'd0,  8'h00},
    '{8'h00, 1'b0, 1'b1, 5'd0,  8'h00},
    '{8'h00, 1'b0, 1'b1, 5'd3,  8'h20},
    '{8'hFF, 1'b0, 1'b1, 5'd0,  8'h00},
    '{8'hFF, 1'b0, 1'b1, 5'd18, 8'h20},
    '{8'h00, 1'b0, 1'b1, 5'd1,  8'h00},
    '{8'hFF, 1'b0, 1'b1, 5'd1,  8'hFF},
    '{8'h41, 1'b0, 1'b1, 5'd1,  8'h41},
    '{8'h42, 1'b0, 1'b1, 5'd1,  8'h42},
    '{8'h43, 1'b0, 1'b1, 5'd1,  8'h43},
    '{8'h44, 1'b0, 1'b1, 5'd1,  8'h44},
    '{8'h00, 1'b0, 1'b1, 5'd0,  8'h00},
    '{8'h08, 1'b0, 1'b1, 5'd0,  8'h00},
    '{8'h02, 1'b0, 1'b0, 5'd0,  8'h00},
    '{8'h03, 1'b0, 1'b1, 5'd0,  8'h00},
    '{8'h03, 1'b0, 1'b0, 5'd0,  8'h00},
    '{8'h10, 1'b1, 1'b1, 5'd0,  8'h00},
    '{8'h01, 1'b0, 1'b1, 5'd0,  8'h00},
    '{8'h5A, 1'b1, 1'b1, 5'd1,  8'h5A},
    '{8'hFF, 1'b1, 1'b1, 5'd0,  8'h00},
    '{8'h00, 1'b0, 1'b1, 5'd0,  8'h00},
    '{8'hEE, 1'b0, 1'b1, 5'd0,  8'h00},
    '{8'hFF, 1'b1, 1'b0, 5'd0,  8'h00}
  };

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  lzss_in_if  in_if ();
  lzss_out_if out_if ();

  lzss_ring_decoder dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  logic [BYTE_W-1:0] ring_copy [RING_N];
  int unsigned       wr_ptr;
  logic [BYTE_W-1:0] flag_reg;
  logic [2:0]        flags_left;
  phase_e            parse_state;
  logic [BYTE_W-1:0] pair_lo;
  logic              refill_due;

  out_item_t   expected_bytes [$];
  out_item_t   step_bytes [$];
  out_item_t   head;
  int unsigned err_count;
  int unsigned burst_left;
  logic [POS_W-1:0] pair_target;

  initial begin
    for (int i = 0; i < RING_N; i++) ring_copy[RING_AW'(i)] = SPACE_BYTE;
    wr_ptr      = REFILL_N % RING_N;
    flag_reg    = '0;
    flags_left  = '0;
    parse_state = PH_FLAG;
    pair_lo     = '0;
    refill_due  = 1'b0;
    err_count   = 0;
    burst_left  = 0;
    pair_target = '0;
  end

  task automatic report_mismatch(input string msg);
    if (err_count < PRINT_CAP) $display("mismatch: %s", msg);
    err_count++;
  endtask

  function automatic void put_ring(input logic [BYTE_W-1:0] v);
    ring_copy[RING_AW'(wr_ptr % RING_N)] = v;
    wr_ptr = (wr_ptr + 1) % RING_N;
  endfunction

  function automatic void next_flag();
    if (flags_left > 0) begin
      flag_reg    = flag_reg >> 1;
      flags_left  = flags_left - 1'b1;
      parse_state = flag_reg[0] ? PH_LIT : PH_PAIR_LO;
    end else begin
      parse_state = PH_FLAG;
    end
  endfunction

  task automatic decode_byte(input logic [BYTE_W-1:0] b, input logic last);
    int unsigned       pos;
    int unsigned       run;
    logic [BYTE_W-1:0] v;
    out_item_t         r;
    step_bytes.delete();
    if (refill_due) begin
      for (int i = 0; i < REFILL_N; i++) ring_copy[RING_AW'(i)] = SPACE_BYTE;
      wr_ptr     = REFILL_N % RING_N;
      refill_due = 1'b0;
    end
    case (parse_state)
      PH_FLAG: begin
        flag_reg    = b;
        flags_left  = FLAGS_PER_BYTE_M1;
        parse_state = b[0] ? PH_LIT : PH_PAIR_LO;
      end
      PH_LIT: begin
        r.data = b;
        r.last = 1'b0;
        step_bytes.push_back(r);
        put_ring(b);
        next_flag();
      end
      PH_PAIR_LO: begin
        pair_lo     = b;
        parse_state = PH_PAIR_HI;
      end
      default: begin
        pos = 32'({b[7:4], pair_lo});
        run = b[3:0] + MIN_RUN;
        for (int k = 0; k < run; k++) begin
          v = ring_copy[RING_AW'((pos + k) % RING_N)];
          put_ring(v);
          r.data = v;
          r.last = 1'b0;
          step_bytes.push_back(r);
        end
        next_flag();
      end
    endcase
    if (last) begin
      if (step_bytes.size() > 0) begin
        r = step_bytes.pop_back();
        r.last = 1'b1;
        step_bytes.push_back(r);
      end
      parse_state = PH_FLAG;
      flags_left  = '0;
      refill_due  = 1'b1;
    end
  endtask

  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic last, input logic typed,
                           input logic [4:0] count, input logic [BYTE_W-1:0] value);
    int unsigned gap;
    out_item_t   r;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_if.valid   <= 1'b1;
    in_if.in_byte <= b;
    in_if.in_last <= last;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    decode_byte(b, last);
    if (typed) begin
      for (int i = 0; i < count; i++) begin
        r.data = value;
        r.last = last && (i == count - 1);
        expected_bytes.push_back(r);
      end
    end else begin
      foreach (step_bytes[i]) expected_bytes.push_back(step_bytes[i]);
    end
  endtask

  task automatic drain_results();
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (expected_bytes.size() != 0);
  endtask

  task automatic send_stream(input int unsigned n_items, input logic noisy, input logic close);
    logic [BYTE_W-1:0] b;
    int unsigned       back;
    for (int unsigned i = 0; i < n_items; i++) begin
      if (noisy) begin
        b = 8'($urandom);
      end else begin
        case (parse_state)
          PH_FLAG: begin
            case ($urandom_range(0, 3))
              0:       b = 8'h00;
              1:       b = 8'hFF;
              default: b = 8'($urandom);
            endcase
          end
          PH_LIT: b = 8'($urandom);
          PH_PAIR_LO: begin
            case ($urandom_range(0, 9))
              0, 1, 2, 3: back = $urandom_range(1, 8);
              4, 5, 6:    back = $urandom_range(1, 300);
              default:    back = $urandom_range(0, RING_N - 1);
            endcase
            pair_target = POS_W'((wr_ptr + RING_N - back) % RING_N);
            b = pair_target[7:0];
          end
          default: b = {pair_target[11:8], 4'($urandom)};
        endcase
      end
      send_byte(b, close && (i == n_items - 1), 1'b0, 5'd0, 8'h00);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      if (expected_bytes.size() == 0) begin
        report_mismatch($sformatf("unexpected byte %02h last %0b", out_if.out_byte,
                                  out_if.out_last));
      end else begin
        head = expected_bytes.pop_front();
        if (out_if.out_byte !== head.data)
          report_mismatch($sformatf("out_byte %02h, expected %02h", out_if.out_byte, head.data));
        if (out_if.out_last !== head.last)
          report_mismatch($sformatf("out_last %0b, expected %0b on byte %02h", out_if.out_last,
                                    head.last, head.data));
      end
    end
  end

  initial begin
    logic [15:0] mask;
    logic [3:0]  slot;
    slot = '0;
    out_if.ready <= 1'b0;
    forever begin
      case ($urandom_range(0, 3))
        0:       mask = 16'hFFFF;
        1:       mask = 16'($urandom);
        2:       mask = 16'h0001;
        default: mask = 16'h00FF;
      endcase
      repeat ($urandom_range(50, 400)) begin
        @(posedge clk_i);
        out_if.ready <= mask[slot];
        slot = slot + 1'b1;
      end
    end
  end

  initial begin
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((in_if.valid === 1'b1 && in_if.ready === 1'b1) ||
          (out_if.valid === 1'b1 && out_if.ready === 1'b1))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    int unsigned sent;
    int unsigned len;
    int unsigned cut;
    logic        noisy;
    in_if.valid   <= 1'b0;
    in_if.in_byte <= '0;
    in_if.in_last <= 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < DIR_ROWS; i++)
      send_byte(DIRECTED[i].data, DIRECTED[i].last, DIRECTED[i].typed, DIRECTED[i].count,
                DIRECTED[i].value);

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      len   = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 90) : $urandom_range(3, 30);
      noisy = ($urandom_range(0, 6) == 0);
      if (sent == 0 || $urandom_range(0, 3) == 0) begin
        cut = $urandom_range(1, len - 1);
        send_stream(cut, noisy, 1'b0);
        drain_results();
        send_stream(len - cut, noisy, 1'b1);
      end else begin
        send_stream(len, noisy, 1'b1);
      end
      sent += len;
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (err_count == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

// File: filelist.f
sv/lzss_pkg.sv
sv/lzss_if.sv
sv/lzss_ring.sv
sv/lzss_mod.sv
sv/lzss_ring_decoder.sv
tb/sv/tb_lzss_ring_decoder.sv
